// ----- rtl/pebt_pkg.sv -----
// Types and codes shared by the pad event binding table.
`default_nettype none
package pebt_pkg;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_LOOKUP = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_IDX = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] pad_code;
    logic [15:0] event_number;
    logic        single_event;
    logic [15:0] press_count;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [5:0]  found_index;
    logic [15:0] event_result;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] pad;
    logic [15:0] evt;
    logic        single;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/pad_event_binding_table.sv -----
// Pad event binding table: compacted entry memory with add, delete, clear, lookup and search.
// Add, clear, unused codes and a bad-index delete: result in the cycle after the beat, no busy.
// Delete: busy while the entries above the deleted one move down, one entry moved per cycle.
// Lookup and search: busy while scanning, one memory read per cycle, stops at first hit.
// done pulses for one cycle with the result, in the same cycle that busy falls; receiver cannot stall.
// Reset clears the entry count and control state; entry memory is not cleared.
`default_nettype none
module pad_event_binding_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  pebt_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output pebt_pkg::rsp_t rsp
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  pebt_pkg::entry_t mem [TABLE_DEPTH];
  pebt_pkg::entry_t rd_data;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] ptr_inc;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic          chk, chk_next;
  logic [CW-1:0] chk_idx, chk_idx_next;
  pebt_pkg::req_t op, op_next;
  logic          done_next;
  pebt_pkg::rsp_t rsp_next;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  pebt_pkg::entry_t mem_wd;
  logic [AW-1:0]    rd_addr;

  logic issue;
  logic hit;
  logic fits;

  assign busy    = (state != S_IDLE);
  assign ptr_inc = ptr + CW'(1);
  assign fits    = rd_data.single ? (op.press_count == 16'd1) : (op.press_count != 16'd0);
  assign hit     = chk && (rd_data.pad == op.pad_code) &&
                   ((op.req_type == pebt_pkg::REQ_SEARCH) || fits);

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    chk_next       = 1'b0;
    chk_idx_next   = chk_idx;
    op_next        = op;
    done_next      = 1'b0;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_wa         = AW'(count);
    mem_wd         = '{pad: req.pad_code, evt: req.event_number, single: req.single_event};
    rd_addr        = AW'(ptr);
    issue          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = req;
          rsp_next = '0;
          case (req.req_type)
            pebt_pkg::REQ_ADD: begin
              done_next = 1'b1;
              if (count >= DEPTH_C) begin
                rsp_next.status = pebt_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
              rsp_next.entry_count = 7'(count_next);
            end
            pebt_pkg::REQ_DELETE: begin
              if (CMPW'(req.entry_index) >= CMPW'(count)) begin
                done_next            = 1'b1;
                rsp_next.status      = pebt_pkg::STAT_BAD_IDX;
                rsp_next.entry_count = 7'(count);
              end else begin
                ptr_next   = CW'(req.entry_index);
                state_next = S_DEL;
              end
            end
            pebt_pkg::REQ_CLEAR: begin
              done_next  = 1'b1;
              count_next = '0;
            end
            pebt_pkg::REQ_LOOKUP, pebt_pkg::REQ_SEARCH: begin
              ptr_next   = '0;
              state_next = S_SCAN;
            end
            default: begin
              done_next            = 1'b1;
              rsp_next.entry_count = 7'(count);
            end
          endcase
        end
      end

      S_DEL: begin
        // read entry above, write it one slot down in the next cycle
        issue   = (ptr_inc < count);
        rd_addr = AW'(ptr_inc);
        if (pend) begin
          mem_we = 1'b1;
          mem_wa = pend_addr;
          mem_wd = rd_data;
        end
        if (issue) begin
          pend_next      = 1'b1;
          pend_addr_next = AW'(ptr);
          ptr_next       = ptr_inc;
        end else begin
          count_next           = count - CW'(1);
          done_next            = 1'b1;
          rsp_next.entry_count = 7'(count_next);
          state_next           = S_IDLE;
        end
      end

      S_SCAN: begin
        issue   = (ptr < count);
        rd_addr = AW'(ptr);
        if (issue) begin
          chk_next     = 1'b1;
          chk_idx_next = ptr;
          ptr_next     = ptr_inc;
        end
        if (hit) begin
          done_next            = 1'b1;
          rsp_next.found       = 1'b1;
          rsp_next.entry_count = 7'(count);
          if (op.req_type == pebt_pkg::REQ_SEARCH) begin
            rsp_next.found_index = 6'(chk_idx);
          end else begin
            rsp_next.event_result = rd_data.evt;
          end
          state_next = S_IDLE;
        end else if (!issue && !chk) begin
          done_next            = 1'b1;
          rsp_next.entry_count = 7'(count);
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      chk   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      chk   <= chk_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    chk_idx   <= chk_idx_next;
    op        <= op_next;
    rsp       <= rsp_next;
  end

endmodule
`default_nettype wire
